>>> rtl/core/svp_pkg.sv
// svp_pkg: shared types and constants of the sampler voice.
// Holds operation and register codes, fixed field widths, reset values and the datapath control.
// No dependencies.
package svp_pkg;

  // fixed field widths
  localparam int ADDR_W    = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 25;
  localparam int STEP_W    = 20;
  localparam int GAIN_W    = 16;
  localparam int ENV_W     = 25;
  localparam int RF_W      = 24;
  localparam int FC_W      = 13;
  localparam int FRAC_W    = 16;

  // envelope limits, Q1.24
  localparam logic [ENV_W-1:0] ENV_ONE   = 25'h100_0000;
  localparam logic [ENV_W-1:0] ENV_FLOOR = 25'd168;

  // register reset values
  localparam logic [STEP_W-1:0] STEP_RESET    = 20'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET    = 16'd11585;
  localparam logic [ENV_W-1:0]  ATTACK_RESET  = 25'd116508;
  localparam logic [RF_W-1:0]   RELEASE_RESET = 24'd16776000;
  localparam logic [FC_W-1:0]   FC_RESET      = 13'd4096;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_START   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE      = 3'd0,
    CFG_GAIN_LEFT      = 3'd1,
    CFG_GAIN_RIGHT     = 3'd2,
    CFG_ATTACK_STEP    = 3'd3,
    CFG_RELEASE_FACTOR = 3'd4,
    CFG_FRAME_COUNT    = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_RD1    = 3'd1,
    ST_INTERP = 3'd2,
    ST_SCALE  = 3'd3,
    ST_ROUND  = 3'd4,
    ST_OUT    = 3'd5
  } state_e;

  // per-stage load strobes of the channel datapath
  typedef struct packed {
    logic ld_eg;
    logic ld_s0;
    logic ld_interp;
    logic ld_prod;
    logic ld_res;
  } dp_ctrl_t;

endpackage

>>> rtl/core/sample_voice_playback.sv
// sample_voice_playback: one stereo sampler voice with linear interpolation between frames.
// Top level: configuration registers, voice state, sequencer, output register.
// Depends on svp_pkg, svp_sample_mem and svp_channel_dp.
//
// Input items carry an operation in s_axis_tuser: load writes one stereo frame into the sample
// store, start rewinds the voice and makes it active, release marks it as releasing and tick
// renders one output frame. Every input item gives exactly one output item; out_left and
// out_right are zero unless the tick renders, voice_running is the voice state after the item.
// One item is worked on at a time. Load, start, release and ticks that do not render go from
// accept straight to the output state; a rendering tick first makes the two reads through the
// single read port of the sample store (frames idx and idx+1) followed by the interpolation,
// scaling and rounding stages. A new item is accepted while the previous result still waits in
// the output register. The store holds SAMPLE_DEPTH frames, is not cleared after reset, and
// every frame must be loaded before a tick reads it. Configuration may only be written while the
// block is idle.
module sample_voice_playback #(
  parameter  int SAMPLE_DEPTH = 4096,
  parameter  int SAMPLE_BITS  = 16,
  localparam int IN_TW  = ((svp_pkg::ADDR_W + 2*SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_TW = ((2*SAMPLE_BITS + 1 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sample_address, sample_left_in, sample_right_in
  input  logic [IN_TW-1:0]              s_axis_tdata,
  // operation
  input  logic [1:0]                    s_axis_tuser,
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_left, out_right, voice_running
  output logic [OUT_TW-1:0]             m_axis_tdata,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [svp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [svp_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import svp_pkg::*;

  localparam int AW  = $clog2(SAMPLE_DEPTH);
  localparam int PW  = AW + FRAC_W;
  localparam int LW  = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
  localparam int CW  = ((AW + 1) > FC_W) ? (AW + 1) : FC_W;
  localparam int SW  = ((PW > STEP_W) ? PW : STEP_W) + 1;
  localparam int MW  = 2 * SAMPLE_BITS;
  localparam logic [SW-1:0] POS_MAX = (SW'(SAMPLE_DEPTH) << FRAC_W) - SW'(1);
  localparam logic [CW-1:0] DEPTH_C = CW'(SAMPLE_DEPTH);
  localparam logic [LW-1:0] DEPTH_L = LW'(SAMPLE_DEPTH);

  // configuration registers
  logic [STEP_W-1:0] step_q;
  logic [GAIN_W-1:0] gain_l_q;
  logic [GAIN_W-1:0] gain_r_q;
  logic [ENV_W-1:0]  attack_q;
  logic [RF_W-1:0]   rf_q;
  logic [FC_W-1:0]   fc_q;

  // voice state
  state_e         state_q, state_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic [ENV_W-1:0] env_q, env_d;
  logic           rel_q, rel_d;
  logic           act_q, act_d;
  logic           render_q, render_d;
  logic           m_valid_q, m_valid_d;
  logic [OUT_TW-1:0] out_data_q;

  // input fields
  op_e                     in_op;
  logic [ADDR_W-1:0]       in_addr;
  logic [SAMPLE_BITS-1:0]  in_left;
  logic [SAMPLE_BITS-1:0]  in_right;
  logic                    in_accept;

  logic [LW-1:0]  addr_ext;
  logic           addr_ok;
  logic           mem_we;
  logic           mem_re;
  logic [AW-1:0]  idx;
  logic [AW-1:0]  idx_next;
  logic [AW-1:0]  rd_addr;
  logic [MW-1:0]  rd_data;
  logic [FRAC_W-1:0] frac;
  logic [CW-1:0]  idx_p1;
  logic [CW-1:0]  fc_ext;
  logic [CW-1:0]  fc_eff;
  logic           end_cond;
  logic [SW-1:0]  pos_sum;
  logic [PW-1:0]  pos_next;
  logic [ENV_W+RF_W-1:0] rel_prod;
  logic [ENV_W:0] att_sum;
  logic [ENV_W-1:0] env_att;
  logic [ENV_W-1:0] env_next;
  dp_ctrl_t       dp_ctrl;
  logic           out_load;
  logic signed [SAMPLE_BITS-1:0] res_l;
  logic signed [SAMPLE_BITS-1:0] res_r;
  logic [SAMPLE_BITS-1:0] out_l;
  logic [SAMPLE_BITS-1:0] out_r;

  // input item fields
  assign in_op     = op_e'(s_axis_tuser);
  assign in_addr   = s_axis_tdata[ADDR_W-1:0];
  assign in_left   = s_axis_tdata[ADDR_W +: SAMPLE_BITS];
  assign in_right  = s_axis_tdata[ADDR_W+SAMPLE_BITS +: SAMPLE_BITS];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_RESET;
      gain_l_q <= GAIN_RESET;
      gain_r_q <= GAIN_RESET;
      attack_q <= ATTACK_RESET;
      rf_q     <= RELEASE_RESET;
      fc_q     <= FC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STEP_SIZE:      step_q   <= cfg_wdata_i[STEP_W-1:0];
        CFG_GAIN_LEFT:      gain_l_q <= cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_RIGHT:     gain_r_q <= cfg_wdata_i[GAIN_W-1:0];
        CFG_ATTACK_STEP:    attack_q <= cfg_wdata_i[ENV_W-1:0];
        CFG_RELEASE_FACTOR: rf_q     <= cfg_wdata_i[RF_W-1:0];
        CFG_FRAME_COUNT:    fc_q     <= cfg_wdata_i[FC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // load address check, loads beyond the store are dropped
  assign addr_ext = LW'(in_addr);
  assign addr_ok  = addr_ext < DEPTH_L;
  assign mem_we   = in_accept && (in_op == OP_LOAD) && addr_ok;

  // read frame idx in the accept cycle, frame idx+1 in the cycle after, in ST_RD1
  assign idx      = pos_q[PW-1:FRAC_W];
  assign frac     = pos_q[FRAC_W-1:0];
  assign idx_next = idx + AW'(1);
  assign rd_addr  = (state_q == ST_RD1) ? idx_next : idx;
  assign mem_re   = (state_q == ST_IDLE) || (state_q == ST_RD1);

  svp_sample_mem #(
    .DEPTH (SAMPLE_DEPTH),
    .WIDTH (MW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (addr_ext[AW-1:0]),
    .wr_data_i ({in_right, in_left}),
    .rd_en_i   (mem_re),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  svp_channel_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp_left (
    .clk_i    (clk_i),
    .ctrl_i   (dp_ctrl),
    .gain_i   (gain_l_q),
    .env_i    (env_q),
    .frac_i   (frac),
    .sample_i (rd_data[SAMPLE_BITS-1:0]),
    .result_o (res_l)
  );

  svp_channel_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp_right (
    .clk_i    (clk_i),
    .ctrl_i   (dp_ctrl),
    .gain_i   (gain_r_q),
    .env_i    (env_q),
    .frac_i   (frac),
    .sample_i (rd_data[MW-1:SAMPLE_BITS]),
    .result_o (res_r)
  );

  // end of voice: next frame at or past the effective count, or release faded out
  assign idx_p1   = CW'(idx) + CW'(1);
  assign fc_ext   = CW'(fc_q);
  assign fc_eff   = (fc_ext < DEPTH_C) ? fc_ext : DEPTH_C;
  assign end_cond = (idx_p1 >= fc_eff) || (rel_q && (env_q < ENV_FLOOR));

  // position advance, saturating at the end of the store
  assign pos_sum  = SW'(pos_q) + SW'(step_q);
  assign pos_next = (pos_sum > POS_MAX) ? POS_MAX[PW-1:0] : pos_sum[PW-1:0];

  // envelope: geometric decay in release, clamped linear rise otherwise
  assign rel_prod = {{RF_W{1'b0}}, env_q} * {{ENV_W{1'b0}}, rf_q};
  assign att_sum  = {1'b0, env_q} + {1'b0, attack_q};
  assign env_att  = (att_sum > {1'b0, ENV_ONE}) ? ENV_ONE : att_sum[ENV_W-1:0];
  assign env_next = rel_q ? rel_prod[RF_W +: ENV_W] : env_att;

  // sequencer: next state, voice state and datapath strobes
  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    env_d    = env_q;
    rel_d    = rel_q;
    act_d    = act_q;
    render_d = render_q;
    dp_ctrl  = '0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          render_d = 1'b0;
          state_d  = ST_OUT;
          unique case (in_op)
            OP_LOAD: begin
            end
            OP_START: begin
              pos_d = '0;
              env_d = '0;
              rel_d = 1'b0;
              act_d = 1'b1;
            end
            OP_RELEASE: begin
              rel_d = 1'b1;
            end
            OP_TICK: begin
              if (act_q) begin
                if (end_cond) begin
                  act_d = 1'b0;
                end else begin
                  render_d      = 1'b1;
                  dp_ctrl.ld_eg = 1'b1;
                  state_d       = ST_RD1;
                end
              end
            end
          endcase
        end
      end
      ST_RD1: begin
        dp_ctrl.ld_s0 = 1'b1;
        state_d       = ST_INTERP;
      end
      ST_INTERP: begin
        dp_ctrl.ld_interp = 1'b1;
        pos_d             = pos_next;
        env_d             = env_next;
        state_d           = ST_SCALE;
      end
      ST_SCALE: begin
        dp_ctrl.ld_prod = 1'b1;
        state_d         = ST_ROUND;
      end
      ST_ROUND: begin
        dp_ctrl.ld_res = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and voice state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      env_q     <= '0;
      rel_q     <= 1'b0;
      act_q     <= 1'b0;
      render_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      env_q     <= env_d;
      rel_q     <= rel_d;
      act_q     <= act_d;
      render_q  <= render_d;
      m_valid_q <= m_valid_d;
    end
  end

  // output register
  assign out_l     = render_q ? res_l : '0;
  assign out_r     = render_q ? res_r : '0;
  assign m_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= OUT_TW'({act_q, out_r, out_l});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> rtl/core/svp_sample_mem.sv
// svp_sample_mem: stereo sample store, one write port and one read port.
// Read data is registered and appears in the cycle after the read; contents are undefined until written.
// No dependencies.
module svp_sample_mem #(
  parameter  int DEPTH = 4096,
  parameter  int WIDTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/svp_channel_dp.sv
// svp_channel_dp: one channel of the render path: envelope gain, interpolation, scaling, saturation.
// Each multiply is followed by a register; the strobes come from the voice sequencer.
// Depends on svp_pkg.
module svp_channel_dp #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  svp_pkg::dp_ctrl_t                  ctrl_i,
  input  logic [svp_pkg::GAIN_W-1:0]         gain_i,
  input  logic [svp_pkg::ENV_W-1:0]          env_i,
  input  logic [svp_pkg::FRAC_W-1:0]         frac_i,
  input  logic signed [SAMPLE_BITS-1:0]      sample_i,
  output logic signed [SAMPLE_BITS-1:0]      result_o
);
  import svp_pkg::*;

  localparam int EGP_W = GAIN_W + ENV_W;
  localparam int EG_SH = 24;
  localparam int IW    = SAMPLE_BITS + FRAC_W + 2;
  localparam int PRW   = IW + GAIN_W + 1;
  localparam int OUT_SH = 30;
  localparam int YW    = PRW - OUT_SH;
  localparam logic [EGP_W-1:0] EG_HALF  = EGP_W'(1) << (EG_SH - 1);
  localparam logic [PRW-1:0]   RND_HALF = PRW'(1) << (OUT_SH - 1);
  localparam logic signed [YW-1:0] Y_MAX =
    $signed({{(YW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [YW-1:0] Y_MIN =
    $signed({{(YW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}});

  logic [EGP_W-1:0]              eg_prod;
  logic [EGP_W-1:0]              eg_round;
  logic [GAIN_W-1:0]             eg_q;
  logic signed [SAMPLE_BITS-1:0] s0_q;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_W:0]        frac_s;
  logic signed [IW-1:0]          mix;
  logic signed [IW-1:0]          s0_ext;
  logic signed [IW-1:0]          interp_d;
  logic signed [IW-1:0]          interp_q;
  logic signed [GAIN_W:0]        eg_s;
  logic signed [PRW-1:0]         prod_d;
  logic signed [PRW-1:0]         prod_q;
  logic signed [PRW-1:0]         rnd;
  logic signed [YW-1:0]          y;
  logic signed [SAMPLE_BITS-1:0] res_d;
  logic signed [SAMPLE_BITS-1:0] res_q;

  // effective gain: gain times envelope, rounded half up to Q2.14
  assign eg_prod  = {{ENV_W{1'b0}}, gain_i} * {{GAIN_W{1'b0}}, env_i};
  assign eg_round = eg_prod + EG_HALF;

  // linear interpolation in Q.16
  assign diff     = {sample_i[SAMPLE_BITS-1], sample_i} - {s0_q[SAMPLE_BITS-1], s0_q};
  assign frac_s   = {1'b0, frac_i};
  assign mix      = diff * frac_s;
  assign s0_ext   = {{(IW-SAMPLE_BITS-FRAC_W){s0_q[SAMPLE_BITS-1]}}, s0_q, {FRAC_W{1'b0}}};
  assign interp_d = s0_ext + mix;

  // scale by effective gain
  assign eg_s   = {1'b0, eg_q};
  assign prod_d = interp_q * eg_s;

  // round half up, drop 30 fraction bits, saturate
  assign rnd = prod_q + $signed(RND_HALF);
  assign y   = rnd[PRW-1:OUT_SH];

  always_comb begin
    if (y > Y_MAX) begin
      res_d = Y_MAX[SAMPLE_BITS-1:0];
    end else if (y < Y_MIN) begin
      res_d = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      res_d = y[SAMPLE_BITS-1:0];
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_eg) begin
      eg_q <= eg_round[EG_SH +: GAIN_W];
    end
    if (ctrl_i.ld_s0) begin
      s0_q <= sample_i;
    end
    if (ctrl_i.ld_interp) begin
      interp_q <= interp_d;
    end
    if (ctrl_i.ld_prod) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.ld_res) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for the sample_voice_playback sampler voice
// depends on svp_pkg and the sample_voice_playback rtl; stream items predicted in-bench

module tb;
  import svp_pkg::*;

  localparam int          DEPTH        = 4096;
  localparam int          IN_TW        = 48;
  localparam int          OUT_TW       = 40;
  localparam int          DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          PRINT_CAP    = 100;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               running;
  } voice_out_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  // sample_address, sample_left_in, sample_right_in
  logic [IN_TW-1:0]  s_axis_tdata;
  // operation
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // out_left, out_right, voice_running
  logic [OUT_TW-1:0] m_axis_tdata;
  logic              cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]  cfg_wdata_i;

  sample_voice_playback dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // voice state as the block should hold it
  logic signed [15:0] store_left  [DEPTH];
  logic signed [15:0] store_right [DEPTH];
  bit                 loaded      [DEPTH];
  logic [27:0]        play_pos;
  logic [24:0]        env_level;
  bit                 release_mark;
  bit                 voice_on;

  // register copies
  logic [STEP_W-1:0]  step_reg;
  logic [GAIN_W-1:0]  gain_l_reg;
  logic [GAIN_W-1:0]  gain_r_reg;
  logic [ENV_W-1:0]   attack_reg;
  logic [RF_W-1:0]    rf_reg;
  logic [FC_W-1:0]    fc_reg;

  voice_out_t  expected_frames[$];
  int unsigned items_sent = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sink_stall_left = 0;
  bit          src_idle_on = 1'b0;
  bit          sink_idle_on = 1'b0;

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver drops ready in bursts of random length while sink idling is on
  always @(negedge clk_i) begin
    if (sink_stall_left != 0) begin
      m_axis_tready   <= 1'b0;
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_idle_on && $urandom_range(0, 11) == 0) begin
      m_axis_tready   <= 1'b0;
      sink_stall_left <= $urandom_range(0, 17);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    if (error_count < PRINT_CAP)
      $display("[%0t] mismatch, %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // compare every output item with the oldest prediction
  always @(posedge clk_i) begin
    voice_out_t want;
    logic signed [15:0] got_left;
    logic signed [15:0] got_right;
    got_left  = m_axis_tdata[15:0];
    got_right = m_axis_tdata[31:16];
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("output item with nothing pending", got_left, 0);
      end else begin
        want = expected_frames.pop_front();
        if (got_left !== want.left)
          report_mismatch("out_left", got_left, want.left);
        if (got_right !== want.right)
          report_mismatch("out_right", got_right, want.right);
        if (m_axis_tdata[32] !== want.running)
          report_mismatch("voice_running", m_axis_tdata[32], want.running);
      end
    end
  end

  // interpolate, apply gain and envelope, round and saturate one channel
  function automatic logic signed [15:0] scale_channel(logic signed [15:0] s0,
      logic signed [15:0] s1, logic [15:0] frac, logic [15:0] gain, logic [24:0] env);
    longint interp;
    longint eg;
    longint y;
    interp = longint'(s0) * 65536 + (longint'(s1) - longint'(s0)) * longint'(frac);
    eg     = (longint'(gain) * longint'(env) + 64'sh80_0000) >>> 24;
    y      = (interp * eg + 64'sh2000_0000) >>> 30;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  // advance the voice by one item and return its output
  function automatic voice_out_t predict_voice_output(op_e op, logic [11:0] addr,
      logic signed [15:0] left_in, logic signed [15:0] right_in);
    voice_out_t  res;
    int unsigned fc_eff;
    int unsigned idx;
    logic [15:0] frac;
    logic [28:0] pos_sum;
    logic [25:0] env_sum;
    logic [48:0] env_prod;
    res.left  = '0;
    res.right = '0;
    case (op)
      OP_LOAD: begin
        store_left[addr]  = left_in;
        store_right[addr] = right_in;
        loaded[addr]      = 1'b1;
      end
      OP_START: begin
        play_pos     = '0;
        env_level    = '0;
        release_mark = 1'b0;
        voice_on     = 1'b1;
      end
      OP_RELEASE: release_mark = 1'b1;
      OP_TICK: if (voice_on) begin
        fc_eff = (fc_reg < DEPTH) ? fc_reg : DEPTH;
        idx    = play_pos[27:16];
        frac   = play_pos[15:0];
        if (idx + 1 >= fc_eff || (release_mark && env_level < ENV_FLOOR)) begin
          voice_on = 1'b0;
        end else begin
          res.left  = scale_channel(store_left[idx], store_left[idx+1], frac,
                                    gain_l_reg, env_level);
          res.right = scale_channel(store_right[idx], store_right[idx+1], frac,
                                    gain_r_reg, env_level);
          // position saturates at the end of the store
          pos_sum  = {1'b0, play_pos} + step_reg;
          play_pos = pos_sum[28] ? '1 : pos_sum[27:0];
          if (release_mark) begin
            env_prod  = env_level * rf_reg;
            env_level = env_prod[48:24];
          end else begin
            env_sum   = env_level + attack_reg;
            env_level = (env_sum > ENV_ONE) ? ENV_ONE : env_sum[24:0];
          end
        end
      end
      default: ;
    endcase
    res.running = voice_on;
    return res;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // present one item, wait for its handshake, then record the prediction
  task automatic send_item(op_e op, logic [11:0] addr, logic signed [15:0] left_in,
      logic signed [15:0] right_in);
    int unsigned gap;
    voice_out_t  pred;
    gap = (src_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {4'b0, right_in, left_in, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_voice_output(op, addr, left_in, right_in);
    expected_frames = {expected_frames, pred};
    items_sent++;
  endtask

  task automatic send_op(op_e op);
    send_item(op, 12'($urandom), rand_sample(), rand_sample());
  endtask

  // a tick that would read frames never loaded gets them loaded first
  task automatic send_tick();
    int unsigned idx;
    idx = play_pos[27:16];
    if (voice_on && idx + 1 < DEPTH) begin
      if (!loaded[idx]) send_item(OP_LOAD, 12'(idx), rand_sample(), rand_sample());
      if (!loaded[idx+1]) send_item(OP_LOAD, 12'(idx + 1), rand_sample(), rand_sample());
    end
    send_op(OP_TICK);
  endtask

  // hold off until every pending output item has come back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e which, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = which;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    case (which)
      CFG_STEP_SIZE:      step_reg   = value[STEP_W-1:0];
      CFG_GAIN_LEFT:      gain_l_reg = value[GAIN_W-1:0];
      CFG_GAIN_RIGHT:     gain_r_reg = value[GAIN_W-1:0];
      CFG_ATTACK_STEP:    attack_reg = value[ENV_W-1:0];
      CFG_RELEASE_FACTOR: rf_reg     = value[RF_W-1:0];
      CFG_FRAME_COUNT:    fc_reg     = value[FC_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 16'hFFFF;
      default: return CFG_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic randomize_regs();
    logic [CFG_W-1:0] step_val;
    logic [CFG_W-1:0] attack_val;
    logic [CFG_W-1:0] rf_val;
    logic [CFG_W-1:0] fc_val;
    case ($urandom_range(0, 5))
      0:       step_val = 0;
      1:       step_val = 20'hFFFFF;
      2:       step_val = 65536;
      default: step_val = CFG_W'($urandom_range(1, 20'h30000));
    endcase
    case ($urandom_range(0, 5))
      0:       attack_val = 0;
      1:       attack_val = ENV_ONE;
      default: attack_val = CFG_W'($urandom_range(1, 25'h40_0000));
    endcase
    case ($urandom_range(0, 5))
      0:       rf_val = 0;
      1:       rf_val = 24'hFFFFFF;
      default: rf_val = CFG_W'($urandom_range(0, 24'hF80000));
    endcase
    case ($urandom_range(0, 9))
      0:       fc_val = CFG_W'($urandom_range(0, 1));
      1:       fc_val = CFG_W'($urandom_range(2, 4096));
      2:       fc_val = CFG_W'($urandom_range(4097, 8191));
      default: fc_val = CFG_W'($urandom_range(2, 64));
    endcase
    write_reg(CFG_STEP_SIZE, step_val);
    write_reg(CFG_GAIN_LEFT, pick_gain());
    write_reg(CFG_GAIN_RIGHT, pick_gain());
    write_reg(CFG_ATTACK_STEP, attack_val);
    write_reg(CFG_RELEASE_FACTOR, rf_val);
    write_reg(CFG_FRAME_COUNT, fc_val);
  endtask

  // start, some ticks, maybe a release and more ticks
  task automatic play_note();
    send_op(OP_START);
    repeat ($urandom_range(1, 24)) send_tick();
    if ($urandom_range(0, 2) != 0) begin
      send_op(OP_RELEASE);
      repeat ($urandom_range(1, 24)) send_tick();
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0:       send_item(OP_LOAD, 12'($urandom), rand_sample(), rand_sample());
      1:       send_op(OP_START);
      2:       send_op(OP_RELEASE);
      default: send_tick();
    endcase
  endtask

  // a tick and a release with no voice, then a note on reset registers
  task automatic test_inactive_voice();
    send_op(OP_TICK);
    send_op(OP_RELEASE);
    send_op(OP_START);
    repeat (3) send_tick();
  endtask

  // full gain and full envelope drive both channels into the rails
  task automatic test_output_saturation();
    wait_drained();
    write_reg(CFG_GAIN_LEFT, 16'hFFFF);
    write_reg(CFG_GAIN_RIGHT, 16'hFFFF);
    write_reg(CFG_ATTACK_STEP, ENV_ONE);
    write_reg(CFG_STEP_SIZE, 20'h08000);
    send_item(OP_LOAD, 12'd0, 16'sh7FFF, 16'sh8000);
    send_item(OP_LOAD, 12'd1, 16'sh7FFF, 16'sh8000);
    send_item(OP_LOAD, 12'd2, 16'sh8000, 16'sh7FFF);
    send_item(OP_LOAD, 12'hFFF, 16'sh8000, 16'sh7FFF);
    send_op(OP_START);
    repeat (4) send_tick();
  endtask

  // release with zero and full decay, release right after start
  task automatic test_release_paths();
    wait_drained();
    write_reg(CFG_RELEASE_FACTOR, 0);
    send_op(OP_START);
    send_tick();
    send_op(OP_RELEASE);
    repeat (2) send_tick();
    send_op(OP_START);
    send_op(OP_RELEASE);
    send_tick();
    wait_drained();
    write_reg(CFG_RELEASE_FACTOR, 24'hFFFFFF);
    send_op(OP_START);
    send_tick();
    send_op(OP_RELEASE);
    send_tick();
  endtask

  // counts of zero, one, two and beyond the store
  task automatic test_frame_count_limits();
    wait_drained();
    write_reg(CFG_FRAME_COUNT, 0);
    send_op(OP_START);
    send_tick();
    wait_drained();
    write_reg(CFG_FRAME_COUNT, 1);
    send_op(OP_START);
    send_tick();
    wait_drained();
    write_reg(CFG_FRAME_COUNT, 2);
    send_op(OP_START);
    repeat (3) send_tick();
    wait_drained();
    write_reg(CFG_FRAME_COUNT, 13'h1FFF);
    send_op(OP_START);
    repeat (2) send_tick();
  endtask

  // largest step runs the voice to the end of a full store
  task automatic test_position_end();
    int unsigned guard;
    wait_drained();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    write_reg(CFG_FRAME_COUNT, FC_RESET);
    write_reg(CFG_STEP_SIZE, 20'hFFFFF);
    write_reg(CFG_ATTACK_STEP, CFG_W'($urandom_range(0, 25'h20_0000)));
    write_reg(CFG_GAIN_LEFT, pick_gain());
    write_reg(CFG_GAIN_RIGHT, pick_gain());
    send_op(OP_START);
    guard = 0;
    while (voice_on && guard < 600) begin
      send_tick();
      guard++;
    end
    send_tick();
  endtask

  // random registers per phase, mostly whole notes with some noise
  task automatic test_random_notes();
    int unsigned phase_end;
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      randomize_regs();
      src_idle_on  = $urandom_range(0, 3) != 0;
      sink_idle_on = $urandom_range(0, 3) != 0;
      phase_end    = items_sent + 50;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) < 7) play_note();
        else send_noise();
      end
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_steady_stream();
    int unsigned phase_end;
    wait_drained();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    randomize_regs();
    phase_end = items_sent + 60;
    while (items_sent < phase_end) play_note();
  endtask

  initial begin
    int unsigned waited;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    m_axis_tready = 1'b1;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_STEP_SIZE;
    cfg_wdata_i   = '0;
    play_pos      = '0;
    env_level     = '0;
    release_mark  = 1'b0;
    voice_on      = 1'b0;
    step_reg      = STEP_RESET;
    gain_l_reg    = GAIN_RESET;
    gain_r_reg    = GAIN_RESET;
    attack_reg    = ATTACK_RESET;
    rf_reg        = RELEASE_RESET;
    fc_reg        = FC_RESET;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_inactive_voice();
    test_output_saturation();
    test_release_paths();
    test_frame_count_limits();
    test_position_end();
    test_random_notes();
    test_steady_stream();

    // final drain, bounded
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    waited = 0;
    while (expected_frames.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_frames.size() != 0)
      report_mismatch("output items missing at end", expected_frames.size(), 0);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
